// ===== src/dfr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dfr_pkg;

  // Field widths fixed by the stream format.
  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 16;
  localparam int HDR_LEN_W = 5;
  localparam int OFF_W     = 4;

  // Header store depth default.
  localparam int HEADER_MAX_DEF = 16;

  // Configuration port geometry: three 32-bit registers at byte addresses 0, 4, 8.
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  // Register reset values. The length limit is the link limit less a safety margin.
  localparam int LINK_LIMIT   = 30000;
  localparam int LINK_MARGIN  = 1000;
  localparam logic [HDR_LEN_W-1:0] HDR_LEN_RST = HDR_LEN_W'(8);
  localparam logic [OFF_W-1:0]     LEN_OFF_RST = OFF_W'(0);
  localparam logic [LEN_W-1:0]     MAX_LEN_RST = LEN_W'(LINK_LIMIT - LINK_MARGIN);

  // Register indexes, taken from paddr[3:2].
  typedef enum logic [1:0] {
    REG_HDR_LEN = 2'd0,
    REG_LEN_OFF = 2'd1,
    REG_MAX_LEN = 2'd2
  } reg_idx_e;

  // Configuration values seen by the datapath.
  typedef struct packed {
    logic [HDR_LEN_W-1:0] header_length;
    logic [OFF_W-1:0]     length_field_offset;
    logic [LEN_W-1:0]     max_total_length;
  } cfg_t;

  // Control of the header store: write one byte, shift toward entry zero, or both.
  typedef struct packed {
    logic wr;
    logic shift;
  } hdr_ctl_t;

endpackage

`default_nettype wire

// ===== src/length_prefixed_packet_deframer_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// A byte that yields a result is loaded into the output register as it is taken.
// Throughput: one byte per cycle while a header is collected and while body bytes pass, unless the
// result stream stalls. An accepted header of L bytes is replayed one byte per cycle from the header
// store while the result stream does not stall; input is held until the replay is done, and a
// one-entry input skid parts the sides. Reset clears the phase, counters, output valid and
// registers (to 8, 0, 29000); the header store is not reset and needs no clearing pass.
module length_prefixed_packet_deframer_core #(
  parameter int HEADER_MAX = dfr_pkg::HEADER_MAX_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Configuration port.
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [dfr_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [dfr_pkg::APB_DATA_W-1:0] pwdata,
  output logic [dfr_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready,
  // Input byte stream.
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [dfr_pkg::BYTE_W-1:0]     data_byte_i,
  // Result stream.
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [dfr_pkg::BYTE_W-1:0]          out_byte_o,
  output logic                                status_o,
  output logic                                first_o,
  output logic                                last_o,
  output logic [dfr_pkg::LEN_W-1:0]           packet_length_o
);

  localparam int IDX_W = $clog2(HEADER_MAX);
  localparam int HL_W  = $clog2(HEADER_MAX + 1);

  dfr_pkg::cfg_t              cfg;
  dfr_pkg::hdr_ctl_t          hdr_ctl;
  logic                       core_valid, core_take;
  logic [dfr_pkg::BYTE_W-1:0] core_byte;
  logic [dfr_pkg::LEN_W-1:0]  hdr_len;
  logic [dfr_pkg::BYTE_W-1:0] hdr_head;
  logic [HL_W-1:0]            hl, off_lim;
  logic [IDX_W-1:0]           off;
  logic                       out_free;

  logic                       phase_q, phase_d;
  logic [dfr_pkg::LEN_W-1:0]  byte_count_q, byte_count_d;
  logic [HL_W-1:0]            rep_left_q, rep_left_d;
  logic                       hdr_only_q, hdr_only_d;
  logic [dfr_pkg::LEN_W-1:0]  pkt_len_q, pkt_len_d;

  logic                       out_valid_q, out_valid_d;
  logic                       out_load;
  logic [dfr_pkg::BYTE_W-1:0] out_byte_q, out_byte_d;
  logic                       out_status_q, out_status_d;
  logic                       out_first_q, out_first_d;
  logic                       out_last_q, out_last_d;
  logic [dfr_pkg::LEN_W-1:0]  out_len_q, out_len_d;

  logic [dfr_pkg::LEN_W-1:0]  cnt_inc;
  logic                       hdr_done, len_bad;

  dfr_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dfr_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (data_byte_i),
    .out_valid_o (core_valid),
    .out_take_i  (core_take),
    .out_data_o  (core_byte)
  );

  dfr_hdr_store #(
    .HEADER_MAX (HEADER_MAX)
  ) u_store (
    .clk_i     (clk_i),
    .ctl_i     (hdr_ctl),
    .wr_idx_i  (byte_count_q[IDX_W-1:0]),
    .wr_data_i (core_byte),
    .rd_off_i  (off),
    .len_o     (hdr_len),
    .head_o    (hdr_head)
  );

  // Effective header length and length field offset, clamped so the field lies in the header.
  always_comb begin
    if (cfg.header_length < dfr_pkg::HDR_LEN_W'(2)) begin
      hl = HL_W'(2);
    end else if (int'(cfg.header_length) > HEADER_MAX) begin
      hl = HL_W'(HEADER_MAX);
    end else begin
      hl = HL_W'(cfg.header_length);
    end
    off_lim = hl - HL_W'(2);
    if (int'(cfg.length_field_offset) > int'(off_lim)) begin
      off = IDX_W'(off_lim);
    end else begin
      off = IDX_W'(cfg.length_field_offset);
    end
  end

  // A byte is taken only when the result register can be loaded and no replay is running.
  assign out_free  = !out_valid_q || !out_stall_i;
  assign core_take = core_valid && (rep_left_q == '0) && out_free;
  assign cnt_inc   = byte_count_q + dfr_pkg::LEN_W'(1);
  assign hdr_done  = cnt_inc >= dfr_pkg::LEN_W'(hl);
  assign len_bad   = (hdr_len < dfr_pkg::LEN_W'(hl)) || (hdr_len > cfg.max_total_length);

  // Deframing control: header collection, replay of the header, body pass-through.
  always_comb begin
    phase_d      = phase_q;
    byte_count_d = byte_count_q;
    rep_left_d   = rep_left_q;
    hdr_only_d   = hdr_only_q;
    pkt_len_d    = pkt_len_q;
    hdr_ctl.wr    = 1'b0;
    hdr_ctl.shift = 1'b0;
    out_load     = 1'b0;
    out_byte_d   = out_byte_q;
    out_status_d = out_status_q;
    out_first_d  = out_first_q;
    out_last_d   = out_last_q;
    out_len_d    = out_len_q;

    if (rep_left_q != '0) begin
      // Replay the next stored header byte.
      if (out_free) begin
        out_load      = 1'b1;
        hdr_ctl.shift = 1'b1;
        out_byte_d    = hdr_head;
        out_status_d  = 1'b0;
        out_first_d   = 1'b0;
        out_last_d    = hdr_only_q && (rep_left_q == HL_W'(1));
        out_len_d     = pkt_len_q;
        rep_left_d    = rep_left_q - HL_W'(1);
      end
    end else if (core_take && phase_q) begin
      // Body byte.
      out_load     = 1'b1;
      out_byte_d   = core_byte;
      out_status_d = 1'b0;
      out_first_d  = 1'b0;
      out_last_d   = cnt_inc >= pkt_len_q;
      out_len_d    = pkt_len_q;
      if (cnt_inc >= pkt_len_q) begin
        phase_d      = 1'b0;
        byte_count_d = '0;
      end else begin
        byte_count_d = cnt_inc;
      end
    end else if (core_take) begin
      // Header byte.
      hdr_ctl.wr = byte_count_q < dfr_pkg::LEN_W'(HEADER_MAX);
      if (!hdr_done) begin
        byte_count_d = cnt_inc;
      end else if (len_bad) begin
        out_load     = 1'b1;
        out_byte_d   = '0;
        out_status_d = 1'b1;
        out_first_d  = 1'b0;
        out_last_d   = 1'b0;
        out_len_d    = hdr_len;
        byte_count_d = '0;
      end else begin
        // Header accepted: emit its first byte now and replay the rest.
        out_load      = 1'b1;
        hdr_ctl.shift = 1'b1;
        out_byte_d    = hdr_head;
        out_status_d  = 1'b0;
        out_first_d   = 1'b1;
        out_last_d    = 1'b0;
        out_len_d     = hdr_len;
        rep_left_d    = hl - HL_W'(1);
        pkt_len_d     = hdr_len;
        hdr_only_d    = hdr_len == dfr_pkg::LEN_W'(hl);
        if (hdr_len == dfr_pkg::LEN_W'(hl)) begin
          byte_count_d = '0;
        end else begin
          phase_d      = 1'b1;
          byte_count_d = dfr_pkg::LEN_W'(hl);
        end
      end
    end
  end

  // Result register valid.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= 1'b0;
      byte_count_q <= '0;
      rep_left_q   <= '0;
      hdr_only_q   <= 1'b0;
      pkt_len_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      byte_count_q <= byte_count_d;
      rep_left_q   <= rep_left_d;
      hdr_only_q   <= hdr_only_d;
      pkt_len_q    <= pkt_len_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_byte_q   <= out_byte_d;
      out_status_q <= out_status_d;
      out_first_q  <= out_first_d;
      out_last_q   <= out_last_d;
      out_len_q    <= out_len_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_byte_o      = out_byte_q;
  assign status_o        = out_status_q;
  assign first_o         = out_first_q;
  assign last_o          = out_last_q;
  assign packet_length_o = out_len_q;

`ifndef SYNTHESIS
  // A rejected header carries no packet byte and no framing marks.
  a_reject_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> !first_o && !last_o && out_byte_o == '0)
    else $error("rejected header result carries packet data");

  // While collecting a header the count never runs past the store depth.
  a_hdr_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !phase_q |-> byte_count_q <= dfr_pkg::LEN_W'(HEADER_MAX))
    else $error("header byte count beyond store depth");

  // In the body the count stays below the latched total length.
  a_body_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> byte_count_q < pkt_len_q)
    else $error("body byte count overran packet length");

  // The replay counter only counts down once a replay is running.
  a_replay_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rep_left_q != '0 |=> rep_left_q <= $past(rep_left_q))
    else $error("replay counter grew during replay");
`endif

endmodule

`default_nettype wire

// ===== src/dfr_skid.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dfr_skid (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [dfr_pkg::BYTE_W-1:0] in_data_i,
  output logic                            out_valid_o,
  input  wire logic                       out_take_i,
  output logic [dfr_pkg::BYTE_W-1:0]      out_data_o
);

  logic                       full_q, full_d;
  logic [dfr_pkg::BYTE_W-1:0] data_q;
  logic                       in_acc;

  // The stall seen upstream is a register, so upstream never waits on downstream logic.
  assign in_stall_o  = full_q;
  assign in_acc      = in_valid_i && !full_q;
  assign out_valid_o = full_q || in_valid_i;
  assign out_data_o  = full_q ? data_q : in_data_i;

  // Park an item when the consumer cannot take it; release it once taken.
  always_comb begin
    full_d = full_q;
    if (full_q && out_take_i) begin
      full_d = 1'b0;
    end else if (in_acc && !out_take_i) begin
      full_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else begin
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && !out_take_i) begin
      data_q <= in_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== src/dfr_hdr_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dfr_hdr_store #(
  parameter int HEADER_MAX = dfr_pkg::HEADER_MAX_DEF
) (
  input  wire logic                          clk_i,
  input  wire dfr_pkg::hdr_ctl_t             ctl_i,
  input  wire logic [$clog2(HEADER_MAX)-1:0] wr_idx_i,
  input  wire logic [dfr_pkg::BYTE_W-1:0]    wr_data_i,
  input  wire logic [$clog2(HEADER_MAX)-1:0] rd_off_i,
  output logic [dfr_pkg::LEN_W-1:0]          len_o,
  output logic [dfr_pkg::BYTE_W-1:0]         head_o
);

  logic [dfr_pkg::BYTE_W-1:0] store_q [HEADER_MAX];
  logic [dfr_pkg::BYTE_W-1:0] view    [HEADER_MAX];
  logic [dfr_pkg::LEN_W-1:0]  pair    [HEADER_MAX-1];

  // Store contents with the byte being written this cycle forwarded in.
  always_comb begin
    for (int i = 0; i < HEADER_MAX; i++) begin
      view[i] = (ctl_i.wr && int'(wr_idx_i) == i) ? wr_data_i : store_q[i];
    end
    for (int i = 0; i < HEADER_MAX - 1; i++) begin
      pair[i] = {view[i], view[i + 1]};
    end
  end

  // The big-endian length is read as one byte pair at the field offset.
  assign len_o  = pair[rd_off_i];
  assign head_o = store_q[0];

  // Replay shifts the header toward entry zero; a byte written in the same cycle
  // lands one place lower so it stays in order.
  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      for (int i = 0; i < HEADER_MAX - 1; i++) begin
        store_q[i] <= (ctl_i.wr && int'(wr_idx_i) == i + 1) ? wr_data_i : store_q[i + 1];
      end
    end else if (ctl_i.wr) begin
      store_q[wr_idx_i] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== src/dfr_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dfr_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [dfr_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [dfr_pkg::APB_DATA_W-1:0] pwdata,
  output logic [dfr_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready,
  output dfr_pkg::cfg_t                       cfg_o
);

  dfr_pkg::cfg_t cfg_q, cfg_d;
  logic          wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg_o  = cfg_q;

  // Register write decode.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr[3:2])
        dfr_pkg::REG_HDR_LEN: cfg_d.header_length       = pwdata[dfr_pkg::HDR_LEN_W-1:0];
        dfr_pkg::REG_LEN_OFF: cfg_d.length_field_offset = pwdata[dfr_pkg::OFF_W-1:0];
        dfr_pkg::REG_MAX_LEN: cfg_d.max_total_length    = pwdata[dfr_pkg::LEN_W-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  // Register read decode.
  always_comb begin
    unique case (paddr[3:2])
      dfr_pkg::REG_HDR_LEN: prdata = dfr_pkg::APB_DATA_W'(cfg_q.header_length);
      dfr_pkg::REG_LEN_OFF: prdata = dfr_pkg::APB_DATA_W'(cfg_q.length_field_offset);
      dfr_pkg::REG_MAX_LEN: prdata = dfr_pkg::APB_DATA_W'(cfg_q.max_total_length);
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_length       <= dfr_pkg::HDR_LEN_RST;
      cfg_q.length_field_offset <= dfr_pkg::LEN_OFF_RST;
      cfg_q.max_total_length    <= dfr_pkg::MAX_LEN_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

// ===== verif/length_prefixed_packet_deframer_core_test.sv =====
`timescale 1ns / 1ps

module length_prefixed_packet_deframer_core_test;

  localparam int BYTE_W        = dfr_pkg::BYTE_W;
  localparam int LEN_W         = dfr_pkg::LEN_W;
  localparam int HDR_LEN_W     = dfr_pkg::HDR_LEN_W;
  localparam int OFF_W         = dfr_pkg::OFF_W;
  localparam int APB_ADDR_W    = dfr_pkg::APB_ADDR_W;
  localparam int APB_DATA_W    = dfr_pkg::APB_DATA_W;
  localparam int HDR_DEPTH     = dfr_pkg::HEADER_MAX_DEF;
  localparam int RANDOM_ITEMS  = 330;
  // Header replay plus the input skid bounds how long the block can stay busy
  // after its last visible result.
  localparam int SETTLE_CYCLES = 2 * HDR_DEPTH + 8;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int MAX_PRINTED   = 10;

  // One result of the block, in port order.
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              status;
    logic              first;
    logic              last;
    logic [LEN_W-1:0]  packet_length;
  } deframed_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_e;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [BYTE_W-1:0]     data_byte_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [BYTE_W-1:0]     out_byte_o;
  logic                  status_o;
  logic                  first_o;
  logic                  last_o;
  logic [LEN_W-1:0]      packet_length_o;

  // Predictor state: register copies and the framing state.
  dfr_pkg::cfg_t     shadow_cfg;
  logic              in_body;
  logic [BYTE_W-1:0] hdr_bytes [HDR_DEPTH];
  logic [LEN_W-1:0]  pkt_count;
  logic [LEN_W-1:0]  pkt_total;
  deframed_t         deframed_q [$];

  // Sender and receiver pacing.
  bit          gaps_on    = 1'b1;
  int unsigned burst_left = 0;
  stall_mode_e stall_mode = STALL_NONE;
  int unsigned stall_left = 0;
  int unsigned stall_tick = 0;

  // Run statistics.
  int unsigned items_sent       = 0;
  int unsigned results_checked  = 0;
  int unsigned packets_accepted = 0;
  int unsigned headers_rejected = 0;
  int unsigned cfg_settings     = 0;
  int unsigned fail_count       = 0;

  length_prefixed_packet_deframer_core #(
    .HEADER_MAX(HDR_DEPTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .status_o       (status_o),
    .first_o        (first_o),
    .last_o         (last_o),
    .packet_length_o(packet_length_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs or drops results.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("TB_ERROR");
    $finish;
  end

  function automatic int unsigned clamp_hdr_len(input int unsigned raw);
    if (raw < 2) return 2;
    if (raw > HDR_DEPTH) return HDR_DEPTH;
    return raw;
  endfunction

  // The length field must lie entirely inside the header.
  function automatic int unsigned clamp_len_off(input int unsigned raw, input int unsigned hl);
    if (raw > hl - 2) return hl - 2;
    return raw;
  endfunction

  task automatic report_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_PRINTED) begin
      $display("%s", msg);
    end
  endtask

  // Append one expected result at the tail of the queue.
  task automatic expect_result(input deframed_t r);
    deframed_q = {deframed_q, r};
  endtask

  // Work out the results that one accepted byte causes.
  task automatic deframe_byte(input logic [BYTE_W-1:0] value);
    int unsigned      hl;
    int unsigned      off;
    logic [LEN_W-1:0] len;
    deframed_t        r;
    hl = clamp_hdr_len(shadow_cfg.header_length);
    if (in_body) begin
      pkt_count       = pkt_count + LEN_W'(1);
      r.out_byte      = value;
      r.status        = 1'b0;
      r.first         = 1'b0;
      r.last          = (pkt_count >= pkt_total);
      r.packet_length = pkt_total;
      expect_result(r);
      if (r.last) begin
        in_body   = 1'b0;
        pkt_count = '0;
      end
    end else begin
      if (pkt_count < HDR_DEPTH) begin
        hdr_bytes[pkt_count] = value;
      end
      pkt_count = pkt_count + LEN_W'(1);
      if (pkt_count >= hl) begin
        off = clamp_len_off(shadow_cfg.length_field_offset, hl);
        len = {hdr_bytes[off], hdr_bytes[off+1]};
        if (len < hl || len > shadow_cfg.max_total_length) begin
          // Bad length: a single status result, then a fresh header.
          r               = '0;
          r.status        = 1'b1;
          r.packet_length = len;
          expect_result(r);
          pkt_count = '0;
          headers_rejected++;
        end else begin
          for (int unsigned i = 0; i < hl; i++) begin
            r.out_byte      = hdr_bytes[i];
            r.status        = 1'b0;
            r.first         = (i == 0);
            r.last          = (len == hl) && (i == hl - 1);
            r.packet_length = len;
            expect_result(r);
          end
          packets_accepted++;
          if (len == hl) begin
            pkt_count = '0;
          end else begin
            in_body   = 1'b1;
            pkt_total = len;
            pkt_count = LEN_W'(hl);
          end
        end
      end
    end
  endtask

  // Send one item, with a random gap before each new burst.
  task automatic send_byte(input logic [BYTE_W-1:0] value);
    if (gaps_on && burst_left == 0) begin
      repeat ($urandom_range(1, 6)) begin
        @(negedge clk_i);
        in_valid_i  = 1'b0;
        data_byte_i = BYTE_W'($urandom);
      end
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk_i);
    in_valid_i  = 1'b1;
    data_byte_i = value;
    do @(posedge clk_i); while (in_stall_o);
    deframe_byte(value);
    items_sent++;
  endtask

  // Hold the input and let every outstanding result drain.
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (deframed_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write one register while idle, with junk above the field, then read it back.
  task automatic cfg_write(input dfr_pkg::reg_idx_e idx, input int unsigned field);
    int unsigned           mask;
    logic [APB_DATA_W-1:0] readback;
    case (idx)
      dfr_pkg::REG_HDR_LEN: mask = (1 << HDR_LEN_W) - 1;
      dfr_pkg::REG_LEN_OFF: mask = (1 << OFF_W) - 1;
      default:              mask = (1 << LEN_W) - 1;
    endcase
    wait_idle();
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = APB_ADDR_W'({idx, 2'b00});
    pwdata  = ($urandom & ~mask) | (field & mask);
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      dfr_pkg::REG_HDR_LEN: shadow_cfg.header_length       = HDR_LEN_W'(field);
      dfr_pkg::REG_LEN_OFF: shadow_cfg.length_field_offset = OFF_W'(field);
      default:              shadow_cfg.max_total_length    = LEN_W'(field);
    endcase
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    readback = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    if (readback !== APB_DATA_W'(field & mask)) begin
      report_failure($sformatf("register %s read back %0h, expected %0h",
                               idx.name(), readback, field & mask));
    end
  endtask

  // Send a header carrying the given total length, then its body if it is acceptable.
  task automatic send_packet(input int unsigned total);
    int unsigned       hl;
    int unsigned       off;
    logic [BYTE_W-1:0] hdr [HDR_DEPTH];
    hl  = clamp_hdr_len(shadow_cfg.header_length);
    off = clamp_len_off(shadow_cfg.length_field_offset, hl);
    for (int unsigned i = 0; i < hl; i++) hdr[i] = BYTE_W'($urandom);
    hdr[off]     = BYTE_W'(total >> 8);
    hdr[off + 1] = BYTE_W'(total);
    for (int unsigned i = 0; i < hl; i++) send_byte(hdr[i]);
    if (total >= hl && total <= shadow_cfg.max_total_length) begin
      repeat (total - hl) send_byte(BYTE_W'($urandom));
    end
  endtask

  // Reset values: an 8-byte header-only packet with the length at offset 0.
  task automatic test_reset_defaults();
    send_byte(8'h00);
    send_byte(8'h08);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h5A);
    send_byte(8'hA5);
    send_byte(8'h01);
    send_byte(8'h80);
  endtask

  // Header length below range clamps to two; lengths at and beyond both bounds.
  task automatic test_length_bounds();
    cfg_write(dfr_pkg::REG_HDR_LEN, 0);
    cfg_write(dfr_pkg::REG_LEN_OFF, 0);
    cfg_write(dfr_pkg::REG_MAX_LEN, 3);
    cfg_settings++;
    // Header-only packet.
    send_byte(8'h00);
    send_byte(8'h02);
    // Length shorter than the header.
    send_byte(8'h00);
    send_byte(8'h01);
    // Length above the limit.
    send_byte(8'h00);
    send_byte(8'h04);
    // Length exactly at the limit, with one body byte.
    send_byte(8'h00);
    send_byte(8'h03);
    send_byte(8'hFF);
  endtask

  // An offset past the header end is pulled back to the last legal position.
  task automatic test_offset_clamp();
    cfg_write(dfr_pkg::REG_HDR_LEN, 3);
    cfg_write(dfr_pkg::REG_LEN_OFF, (1 << OFF_W) - 1);
    cfg_settings++;
    send_byte(8'hAA);
    send_byte(8'h00);
    send_byte(8'h03);
  endtask

  // Shrinking the header length while a header is half collected.
  task automatic test_header_resize_midway();
    cfg_write(dfr_pkg::REG_HDR_LEN, 4);
    cfg_write(dfr_pkg::REG_LEN_OFF, 0);
    cfg_write(dfr_pkg::REG_MAX_LEN, 100);
    cfg_settings++;
    send_byte(8'h00);
    send_byte(8'h02);
    cfg_write(dfr_pkg::REG_HDR_LEN, 2);
    send_byte(8'h77);
  endtask

  // Register changes in the middle of a body must not move its end.
  task automatic test_regs_change_mid_body();
    cfg_write(dfr_pkg::REG_HDR_LEN, 2);
    cfg_settings++;
    send_byte(8'h00);
    send_byte(8'h04);
    send_byte(8'hC3);
    cfg_write(dfr_pkg::REG_HDR_LEN, 5);
    cfg_write(dfr_pkg::REG_MAX_LEN, 0);
    send_byte(8'h3C);
  endtask

  // Phases of random settings, each carrying a few packets, bad headers and noise.
  task automatic test_random_traffic();
    int unsigned goal;
    int unsigned raw_hl;
    int unsigned raw_off;
    int unsigned hl;
    int unsigned max_len;
    int unsigned total;
    int unsigned pick;
    int unsigned hi;
    goal = items_sent + RANDOM_ITEMS;
    while (items_sent < goal) begin
      case ($urandom_range(0, 7))
        0:       raw_hl = $urandom_range(0, 1);
        1:       raw_hl = 2;
        2:       raw_hl = HDR_DEPTH;
        3:       raw_hl = $urandom_range(HDR_DEPTH + 1, (1 << HDR_LEN_W) - 1);
        default: raw_hl = $urandom_range(2, 8);
      endcase
      hl = clamp_hdr_len(raw_hl);
      case ($urandom_range(0, 4))
        0:       raw_off = 0;
        1:       raw_off = (1 << OFF_W) - 1;
        2:       raw_off = hl - 2;
        default: raw_off = $urandom_range(0, (1 << OFF_W) - 1);
      endcase
      case ($urandom_range(0, 9))
        0:       max_len = 0;
        1:       max_len = (1 << LEN_W) - 1;
        2:       max_len = hl;
        default: max_len = hl + $urandom_range(0, 40);
      endcase
      cfg_write(dfr_pkg::REG_HDR_LEN, raw_hl);
      cfg_write(dfr_pkg::REG_LEN_OFF, raw_off);
      cfg_write(dfr_pkg::REG_MAX_LEN, max_len);
      cfg_settings++;
      gaps_on = ($urandom_range(0, 3) != 0);

      repeat ($urandom_range(2, 5)) begin
        pick = $urandom_range(0, 99);
        if (pick >= 88 && max_len <= hl + 64) begin
          // Raw noise, then keep feeding bytes until the framing is back at a header start.
          repeat ($urandom_range(1, 10)) send_byte(BYTE_W'($urandom));
          while (in_body || pkt_count != 0) send_byte(BYTE_W'($urandom));
        end else if (pick >= 75) begin
          if ($urandom_range(0, 1) == 0 || max_len == (1 << LEN_W) - 1) begin
            total = $urandom_range(0, hl - 1);
          end else begin
            hi = max_len + 300;
            if (hi > (1 << LEN_W) - 1) hi = (1 << LEN_W) - 1;
            total = $urandom_range(max_len + 1, hi);
          end
          send_packet(total);
        end else begin
          total = hl + (($urandom_range(0, 4) != 0) ? $urandom_range(0, 8)
                                                    : $urandom_range(0, 40));
          if (total > max_len && max_len >= hl) total = max_len;
          send_packet(total);
        end
      end
    end
  endtask

  // Receiver back-pressure: a random mode, chosen afresh whenever its hold counter runs out.
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_left = $urandom_range(40, 200);
    end else begin
      stall_left--;
    end
    stall_tick++;
    case (stall_mode)
      STALL_NONE:  out_stall_i = 1'b0;
      STALL_LIGHT: out_stall_i = ($urandom_range(0, 7) == 0);
      STALL_HEAVY: out_stall_i = ($urandom_range(0, 1) == 0);
      default:     out_stall_i = ((stall_tick % 7) < 3);
    endcase
  end

  // Compare every accepted result with the oldest expected one.
  always @(posedge clk_i) begin
    deframed_t seen;
    deframed_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen.out_byte      = out_byte_o;
      seen.status        = status_o;
      seen.first         = first_o;
      seen.last          = last_o;
      seen.packet_length = packet_length_o;
      results_checked++;
      if (deframed_q.size() == 0) begin
        report_failure($sformatf(
          "unexpected result: byte %02h status %0b first %0b last %0b length %0d",
          seen.out_byte, seen.status, seen.first, seen.last, seen.packet_length));
      end else begin
        want = deframed_q[0];
        deframed_q.delete(0);
        if (seen !== want) begin
          report_failure($sformatf({"result %0d mismatch: expected byte %02h status %0b ",
            "first %0b last %0b length %0d, got byte %02h status %0b first %0b ",
            "last %0b length %0d"}, results_checked,
            want.out_byte, want.status, want.first, want.last, want.packet_length,
            seen.out_byte, seen.status, seen.first, seen.last, seen.packet_length));
        end
      end
    end
  end

  initial begin
    rst_ni      = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_valid_i  = 1'b0;
    data_byte_i = '0;
    shadow_cfg.header_length       = dfr_pkg::HDR_LEN_RST;
    shadow_cfg.length_field_offset = dfr_pkg::LEN_OFF_RST;
    shadow_cfg.max_total_length    = dfr_pkg::MAX_LEN_RST;
    in_body   = 1'b0;
    pkt_count = '0;
    pkt_total = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_defaults();
    test_length_bounds();
    test_offset_clamp();
    test_header_resize_midway();
    test_regs_change_mid_body();
    test_random_traffic();

    wait_idle();
    $display("Sent %0d bytes over %0d register settings; checked %0d results.",
             items_sent, cfg_settings + 1, results_checked);
    $display("Packets accepted: %0d, headers rejected: %0d, failures: %0d.",
             packets_accepted, headers_rejected, fail_count);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
